// ===== rtl/btmx_pkg.sv =====
package btmx_pkg;

  localparam int KEY_W    = 36;
  localparam int OPCODE_W = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

// ===== rtl/binary_trie_max_xor.sv =====
// Binary trie over KEY_BITS-bit keys answering maximum-xor queries. Each transfer on the
// in_ channel carries one operation (insert, query, clear) and produces exactly one
// transfer on the out_ channel. Insert and query walk the trie one level per cycle from
// the most significant key bit, with one read of the child-link memory (NODES words of
// two links each, read data registered) per level. Clear, a refused insert (fewer than
// KEY_BITS free nodes), a query on an empty trie and an unused opcode skip the walk and
// go straight to the result. The root links live in flip-flops, so clear is immediate
// and no memory clearing pass is needed; other nodes are initialized as they are
// allocated. A finished result waits in an output register, and the next operation is
// accepted while it waits.
module binary_trie_max_xor #(
  parameter int KEY_BITS = 36,
  parameter int NODES    = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [btmx_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [btmx_pkg::KEY_W-1:0]     in_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [btmx_pkg::KEY_W-1:0]     out_best_key,
  output logic [btmx_pkg::STATUS_W-1:0]  out_status
);

  localparam int LW  = $clog2(NODES);
  localparam int LVW = $clog2(KEY_BITS);
  localparam int WW  = 2 * LW;

  // node memory: two links per word, link for bit 0 in the low half
  logic [WW-1:0] mem [NODES];

  btmx_pkg::state_t            state_r, state_nxt;
  logic [LW-1:0]               used_r, used_nxt;
  logic                        empty_r, empty_nxt;
  logic [WW-1:0]               root_r, root_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic [KEY_BITS-1:0]         key_r, key_nxt;
  logic [LVW-1:0]              lvl_r, lvl_nxt;
  logic [LW-1:0]               cur_r, cur_nxt;
  logic                        at_root_r, at_root_nxt;
  logic                        alloc_r, alloc_nxt;
  logic [KEY_BITS-1:0]         acc_r, acc_nxt;
  logic                        op_ins_r, op_ins_nxt;
  logic [btmx_pkg::KEY_W-1:0]  res_best_r, res_best_nxt;
  btmx_pkg::status_t           res_status_r, res_status_nxt;
  logic [btmx_pkg::KEY_W-1:0]  out_best_r, out_best_nxt;
  btmx_pkg::status_t           out_status_r, out_status_nxt;

  logic [WW-1:0]               rd_data_r;
  logic [LW-1:0]               rd_addr;
  logic                        mem_we;
  logic [LW-1:0]               wr_addr;
  logic [WW-1:0]               wr_word;

  logic [WW-1:0]               links;
  logic [LW-1:0]               link_b, link_o, new_id, qry_nxt;
  logic                        key_bit, full;
  logic                        in_xfer, out_free;

  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign links   = alloc_r ? '0 : (at_root_r ? root_r : rd_data_r);
  assign key_bit = key_r[lvl_r];
  assign link_b  = key_bit ? links[WW-1:LW] : links[LW-1:0];
  assign link_o  = key_bit ? links[LW-1:0] : links[WW-1:LW];
  assign new_id  = LW'(used_r + LW'(1));
  assign wr_word = key_bit ? {new_id, link_o} : {link_o, new_id};
  assign qry_nxt = (link_o != '0) ? link_o : link_b;
  assign full    = ((LW+1)'(used_r) + (LW+1)'(KEY_BITS)) > (LW+1)'(NODES - 1);
  assign wr_addr = cur_r;
  assign rd_addr = cur_nxt;

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    empty_nxt      = empty_r;
    root_nxt       = root_r;
    out_valid_nxt  = out_valid_r;
    key_nxt        = key_r;
    lvl_nxt        = lvl_r;
    cur_nxt        = cur_r;
    at_root_nxt    = at_root_r;
    alloc_nxt      = alloc_r;
    acc_nxt        = acc_r;
    op_ins_nxt     = op_ins_r;
    res_best_nxt   = res_best_r;
    res_status_nxt = res_status_r;
    out_best_nxt   = out_best_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      btmx_pkg::S_IDLE: begin
        if (in_xfer) begin
          key_nxt        = KEY_BITS'(in_key);
          lvl_nxt        = LVW'(KEY_BITS - 1);
          cur_nxt        = '0;
          at_root_nxt    = 1'b1;
          alloc_nxt      = 1'b0;
          acc_nxt        = '0;
          res_best_nxt   = '0;
          res_status_nxt = btmx_pkg::ST_OK;
          state_nxt      = btmx_pkg::S_DONE;
          unique case (in_opcode)
            btmx_pkg::OP_INSERT: begin
              op_ins_nxt = 1'b1;
              if (full) begin
                res_status_nxt = btmx_pkg::ST_FULL;
              end else begin
                state_nxt = btmx_pkg::S_WALK;
              end
            end
            btmx_pkg::OP_QUERY: begin
              op_ins_nxt = 1'b0;
              if (empty_r) begin
                res_status_nxt = btmx_pkg::ST_EMPTY;
              end else begin
                state_nxt = btmx_pkg::S_WALK;
              end
            end
            btmx_pkg::OP_CLEAR: begin
              root_nxt  = '0;
              used_nxt  = '0;
              empty_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      btmx_pkg::S_WALK: begin
        at_root_nxt = 1'b0;
        lvl_nxt     = lvl_r - LVW'(1);
        if (op_ins_r) begin
          if (link_b == '0) begin
            // allocate; every deeper level allocates as well
            used_nxt  = new_id;
            cur_nxt   = new_id;
            alloc_nxt = 1'b1;
            if (at_root_r) begin
              root_nxt = wr_word;
            end else begin
              mem_we = 1'b1;
            end
          end else begin
            cur_nxt = link_b;
          end
          if (lvl_r == '0) begin
            empty_nxt = 1'b0;
            state_nxt = btmx_pkg::S_DONE;
          end
        end else begin
          if (qry_nxt == '0) begin
            res_best_nxt = btmx_pkg::KEY_W'(acc_r);
            state_nxt    = btmx_pkg::S_DONE;
          end else begin
            acc_nxt        = acc_r;
            acc_nxt[lvl_r] = (link_o != '0) ? !key_bit : key_bit;
            cur_nxt        = qry_nxt;
            if (lvl_r == '0) begin
              res_best_nxt = btmx_pkg::KEY_W'(acc_nxt);
              state_nxt    = btmx_pkg::S_DONE;
            end
          end
        end
      end

      btmx_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_best_nxt   = res_best_r;
          out_status_nxt = res_status_r;
          state_nxt      = btmx_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = btmx_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btmx_pkg::S_IDLE;
      used_r      <= '0;
      empty_r     <= 1'b1;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      empty_r     <= empty_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    lvl_r        <= lvl_nxt;
    cur_r        <= cur_nxt;
    at_root_r    <= at_root_nxt;
    alloc_r      <= alloc_nxt;
    acc_r        <= acc_nxt;
    op_ins_r     <= op_ins_nxt;
    res_best_r   <= res_best_nxt;
    res_status_r <= res_status_nxt;
    out_best_r   <= out_best_nxt;
    out_status_r <= out_status_nxt;
  end

  // child-link memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign in_stall     = (state_r != btmx_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_best_key = out_best_r;
  assign out_status   = out_status_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (LW+1)'(used_r) <= (LW+1)'(NODES - 1))
    else $error("node count beyond store");

  a_root_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == btmx_pkg::S_IDLE && empty_r) |-> (root_r == '0))
    else $error("empty trie with root links");

  a_no_root_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (wr_addr != '0 && !at_root_r))
    else $error("memory write outside allocation");

  a_status_best: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != btmx_pkg::ST_OK) |-> (out_best_r == '0))
    else $error("nonzero key with error status");

endmodule

// ===== test/tb_binary_trie_max_xor.sv =====
`timescale 1ns / 100ps

module tb_binary_trie_max_xor;

  localparam int KEY_BITS = 36;
  localparam int NODES = 4096;
  localparam logic [btmx_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = KEY_BITS + 4;

  typedef struct packed {
    logic [btmx_pkg::KEY_W-1:0] best_key;
    btmx_pkg::status_t status;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [btmx_pkg::OPCODE_W-1:0] in_opcode = '0;
  logic [btmx_pkg::KEY_W-1:0] in_key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [btmx_pkg::KEY_W-1:0] out_best_key;
  logic [btmx_pkg::STATUS_W-1:0] out_status;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int errors = 0;
  int n_insert = 0;
  int n_refused = 0;
  int n_query = 0;
  int n_empty_query = 0;
  int n_clear = 0;
  int n_unused = 0;
  int n_replies = 0;

  // trie mirror
  int link_mem [0:2*NODES-1];
  int nodes_used = 0;
  bit trie_empty = 1'b1;
  logic [btmx_pkg::KEY_W-1:0] stored_keys [$];
  reply_t pending_replies [$];

  binary_trie_max_xor #(
    .KEY_BITS(KEY_BITS),
    .NODES(NODES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_best_key(out_best_key),
    .out_status(out_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic reply_t trie_apply(input logic [btmx_pkg::OPCODE_W-1:0] op,
                                        input logic [btmx_pkg::KEY_W-1:0] key);
    reply_t r;
    int cur;
    int nxt;
    int kbit;
    int want;
    r.best_key = '0;
    r.status = btmx_pkg::ST_OK;
    case (op)
      btmx_pkg::OP_INSERT: begin
        n_insert++;
        if (nodes_used > NODES - 1 || NODES - 1 - nodes_used < KEY_BITS) begin
          r.status = btmx_pkg::ST_FULL;
          n_refused++;
        end else begin
          cur = 0;
          for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            kbit = key[lvl];
            nxt = link_mem[cur*2 + kbit];
            if (nxt == 0) begin
              nodes_used++;
              nxt = nodes_used;
              link_mem[nxt*2] = 0;
              link_mem[nxt*2 + 1] = 0;
              link_mem[cur*2 + kbit] = nxt;
            end
            cur = nxt;
          end
          trie_empty = 1'b0;
          stored_keys.push_back(key);
        end
      end
      btmx_pkg::OP_QUERY: begin
        n_query++;
        if (trie_empty) begin
          r.status = btmx_pkg::ST_EMPTY;
          n_empty_query++;
        end else begin
          cur = 0;
          for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            kbit = key[lvl];
            want = kbit ^ 1;
            nxt = link_mem[cur*2 + want];
            if (nxt == 0) begin
              nxt = link_mem[cur*2 + kbit];
              want = kbit;
            end
            if (nxt == 0) break;
            r.best_key[lvl] = want[0];
            cur = nxt;
          end
        end
      end
      btmx_pkg::OP_CLEAR: begin
        n_clear++;
        link_mem[0] = 0;
        link_mem[1] = 0;
        nodes_used = 0;
        trie_empty = 1'b1;
        stored_keys.delete();
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  function automatic logic [btmx_pkg::KEY_W-1:0] rand_key();
    return btmx_pkg::KEY_W'({$urandom, $urandom});
  endfunction

  function automatic logic [btmx_pkg::KEY_W-1:0] low_mask();
    return (36'd1 << $urandom_range(1, KEY_BITS - 1)) - 36'd1;
  endfunction

  function automatic logic [btmx_pkg::KEY_W-1:0] near_key(
      input logic [btmx_pkg::KEY_W-1:0] base);
    logic [btmx_pkg::KEY_W-1:0] k;
    k = base ^ (rand_key() & low_mask());
    if ($urandom_range(3) == 0) k[$urandom_range(KEY_BITS - 1)] ^= 1'b1;
    return k;
  endfunction

  function automatic logic [btmx_pkg::KEY_W-1:0] query_key(
      input logic [btmx_pkg::KEY_W-1:0] base);
    logic [btmx_pkg::KEY_W-1:0] s;
    if (stored_keys.size() == 0) return rand_key();
    s = stored_keys[$urandom_range(stored_keys.size() - 1)];
    case ($urandom_range(3))
      0: return rand_key();
      1: return s ^ (rand_key() & low_mask());
      2: return ~s;
      default: return near_key(base);
    endcase
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic send_op(input logic [btmx_pkg::OPCODE_W-1:0] op,
                         input logic [btmx_pkg::KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key <= key;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(trie_apply(op, key));
    @(negedge clk);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct, input int hold);
    @(posedge clk);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    hold_cycles = hold;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    reply_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_replies++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result: actual best_key %h status %0d",
                 $time, out_best_key, out_status);
        errors++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_best_key !== exp_r.best_key) begin
          $display("%0t: best_key mismatch: expected %h, actual %h",
                   $time, exp_r.best_key, out_best_key);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, exp_r.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic test_corner_cases();
    send_op(btmx_pkg::OP_QUERY, '1);
    send_op(OP_UNUSED, rand_key());
    send_op(btmx_pkg::OP_CLEAR, rand_key());
    send_op(btmx_pkg::OP_QUERY, '0);
    send_op(btmx_pkg::OP_INSERT, '0);
    send_op(btmx_pkg::OP_INSERT, '0);
    send_op(btmx_pkg::OP_QUERY, '0);
    send_op(btmx_pkg::OP_QUERY, '1);
    send_op(btmx_pkg::OP_INSERT, '1);
    send_op(btmx_pkg::OP_QUERY, '0);
    send_op(btmx_pkg::OP_QUERY, '1);
    send_op(btmx_pkg::OP_INSERT, 36'h8_0000_0000);
    send_op(btmx_pkg::OP_QUERY, 36'h7_ffff_ffff);
    send_op(btmx_pkg::OP_QUERY, 36'h5_5555_5555);
    send_op(OP_UNUSED, '1);
    send_op(btmx_pkg::OP_CLEAR, '1);
    send_op(btmx_pkg::OP_QUERY, 36'h0_0000_0001);
    send_op(btmx_pkg::OP_INSERT, 36'h5_5555_5555);
    send_op(btmx_pkg::OP_QUERY, 36'h0_0000_0000);
    send_op(btmx_pkg::OP_QUERY, 36'ha_aaaa_aaaa);
  endtask

  // receiver holds off while the sender keeps offering transfers
  task automatic test_output_backpressure();
    logic [btmx_pkg::KEY_W-1:0] base;
    base = rand_key();
    set_idling(0, 0, 400);
    repeat (16) begin
      if ($urandom_range(1)) send_op(btmx_pkg::OP_INSERT, near_key(base));
      else send_op(btmx_pkg::OP_QUERY, query_key(base));
    end
  endtask

  task automatic test_store_full();
    logic [btmx_pkg::KEY_W-1:0] base;
    base = rand_key();
    send_op(btmx_pkg::OP_CLEAR, rand_key());
    while (NODES - 1 - nodes_used >= KEY_BITS) begin
      if ($urandom_range(3) == 0) send_op(btmx_pkg::OP_QUERY, query_key(base));
      else if ($urandom_range(1)) send_op(btmx_pkg::OP_INSERT, rand_key());
      else send_op(btmx_pkg::OP_INSERT, near_key(base));
    end
    send_op(btmx_pkg::OP_INSERT, stored_keys[$urandom_range(stored_keys.size() - 1)]);
    send_op(btmx_pkg::OP_INSERT, rand_key());
    repeat (4) send_op(btmx_pkg::OP_QUERY, query_key(base));
    send_op(OP_UNUSED, rand_key());
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent;
    int len;
    logic [btmx_pkg::KEY_W-1:0] base;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0: begin
          send_op(btmx_pkg::OP_CLEAR, rand_key());
          sent++;
        end
        1: send_op(OP_UNUSED, rand_key());
        default: begin
          base = rand_key();
          len = $urandom_range(2, 12);
          repeat (len) begin
            if ($urandom_range(1)) send_op(btmx_pkg::OP_INSERT, near_key(base));
            else send_op(btmx_pkg::OP_QUERY, query_key(base));
          end
          sent += len;
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < 2*NODES; i++) link_mem[i] = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_corner_cases();
    test_output_backpressure();

    set_idling(8, 70, 0);
    test_random_traffic(100);
    test_store_full();

    set_idling(70, 8, 0);
    test_random_traffic(100);
    test_store_full();

    set_idling(0, 0, 0);
    test_random_traffic(100);
    test_store_full();

    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d result transfers: %0d inserts (%0d refused on a full store),",
             n_replies, n_insert, n_refused);
    $display("%0d queries (%0d on an empty trie), %0d clears, %0d unused opcodes",
             n_query, n_empty_query, n_clear, n_unused);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== binary_trie_max_xor.f =====
rtl/btmx_pkg.sv
rtl/binary_trie_max_xor.sv
test/tb_binary_trie_max_xor.sv
